FILE: sv/lcdws_pkg.sv
// Shared types, constants and microcode for the character LCD write sequencer.
// No dependencies; used by every module of the block.
package lcdws_pkg;

    localparam int PULSE_US      = 2000;
    localparam int INIT_WAIT_US  = 200000;
    localparam int CLEAR_WAIT_US = 10000;
    localparam int CMD_GAP_US    = 1000;

    localparam int HOLD_W   = 18;
    localparam int HOLD_MAX = 262143;
    localparam int PC_W     = 6;
    localparam int ROM_DEPTH = 33;

    localparam logic [7:0] ROW1_BASE = 8'h80;
    localparam logic [7:0] ROW2_BASE = 8'hC0;
    localparam logic [7:0] ROW3_BASE = 8'h94;
    localparam logic [7:0] ROW4_BASE = 8'hD4;

    localparam logic [PC_W-1:0] ENT_CHAR  = PC_W'(0);
    localparam logic [PC_W-1:0] ENT_CMD   = PC_W'(4);
    localparam logic [PC_W-1:0] ENT_CLEAR = PC_W'(8);
    localparam logic [PC_W-1:0] ENT_INIT  = PC_W'(12);

    function automatic logic [HOLD_W-1:0] sat_hold(input int v);
        logic [HOLD_W-1:0] r;
        r = (v > HOLD_MAX) ? HOLD_W'(HOLD_MAX) : HOLD_W'(v);
        return r;
    endfunction

    localparam logic [HOLD_W-1:0] HOLD_PULSE_VAL = sat_hold(PULSE_US);
    localparam logic [HOLD_W-1:0] HOLD_GAP_VAL   = sat_hold(PULSE_US + CMD_GAP_US);
    localparam logic [HOLD_W-1:0] HOLD_CLEAR_VAL = sat_hold(PULSE_US + CLEAR_WAIT_US);
    localparam logic [HOLD_W-1:0] HOLD_INIT_VAL  = sat_hold(INIT_WAIT_US);

    typedef enum logic [2:0] {
        KIND_CHAR   = 3'd0,
        KIND_CMD    = 3'd1,
        KIND_CURSOR = 3'd2,
        KIND_INIT   = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        CFG_FOUR_BIT  = 3'd0,
        CFG_FUNC_SET  = 3'd1,
        CFG_DISP_ON   = 3'd2,
        CFG_ENTRY     = 3'd3,
        CFG_HOME      = 3'd4,
        CFG_CLEAR     = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        SRC_ZERO  = 3'd0,
        SRC_REQ   = 3'd1,
        SRC_HOME  = 3'd2,
        SRC_FUNC  = 3'd3,
        SRC_DISP  = 3'd4,
        SRC_CLEAR = 3'd5,
        SRC_ENTRY = 3'd6
    } src_t;

    typedef enum logic [1:0] {
        HOLD_PULSE = 2'd0,
        HOLD_GAP   = 2'd1,
        HOLD_CLEAR = 2'd2,
        HOLD_INIT  = 2'd3
    } hold_sel_t;

    typedef struct packed {
        src_t      src;
        logic      nib_hi;
        logic      four_only;
        logic      rs;
        logic      en;
        hold_sel_t hold;
        logic      last;
    } uword_t;

    typedef struct packed {
        logic       four_bit_mode;
        logic [7:0] function_set_cmd;
        logic [7:0] display_on_cmd;
        logic [7:0] entry_mode_cmd;
        logic [7:0] home_cmd;
        logic [7:0] clear_cmd;
    } cfg_t;

    // One byte transfer: high nibble pulse, low nibble pulse (low only in 8-bit mode).
    function automatic uword_t byte_word(input src_t src, input logic rs,
                                         input logic four_only, input hold_sel_t hold_end,
                                         input logic last_end, input logic [1:0] off);
        uword_t w;
        w.src       = src;
        w.rs        = rs;
        w.four_only = four_only;
        w.nib_hi    = ~off[1];
        w.en        = ~off[0];
        w.hold      = (off == 2'd3) ? hold_end : HOLD_PULSE;
        w.last      = (off == 2'd3) ? last_end : 1'b0;
        return w;
    endfunction

    function automatic uword_t ucode(input logic [PC_W-1:0] addr);
        uword_t          w;
        logic [PC_W-1:0] rel;
        rel = PC_W'(addr - (ENT_INIT + PC_W'(1)));
        w = byte_word(SRC_ZERO, 1'b0, 1'b0, HOLD_PULSE, 1'b1, 2'd3);
        if (addr < ENT_CMD) begin
            w = byte_word(SRC_REQ, 1'b1, 1'b0, HOLD_PULSE, 1'b1, addr[1:0]);
        end
        else if (addr < ENT_CLEAR) begin
            w = byte_word(SRC_REQ, 1'b0, 1'b0, HOLD_PULSE, 1'b1, addr[1:0]);
        end
        else if (addr < ENT_INIT) begin
            w = byte_word(SRC_CLEAR, 1'b0, 1'b0, HOLD_CLEAR, 1'b1, addr[1:0]);
        end
        else if (addr == ENT_INIT) begin
            w = '{src: SRC_ZERO, nib_hi: 1'b0, four_only: 1'b0, rs: 1'b0, en: 1'b0,
                  hold: HOLD_INIT, last: 1'b0};
        end
        else begin
            case (rel[4:2])
                3'd0: w = byte_word(SRC_HOME, 1'b0, 1'b1, HOLD_GAP, 1'b0, rel[1:0]);
                3'd1: w = byte_word(SRC_FUNC, 1'b0, 1'b0, HOLD_GAP, 1'b0, rel[1:0]);
                3'd2: w = byte_word(SRC_DISP, 1'b0, 1'b0, HOLD_GAP, 1'b0, rel[1:0]);
                3'd3: w = byte_word(SRC_CLEAR, 1'b0, 1'b0, HOLD_CLEAR, 1'b0, rel[1:0]);
                3'd4: w = byte_word(SRC_ENTRY, 1'b0, 1'b0, HOLD_GAP, 1'b1, rel[1:0]);
                default: w = byte_word(SRC_ZERO, 1'b0, 1'b0, HOLD_PULSE, 1'b1, 2'd3);
            endcase
        end
        return w;
    endfunction

endpackage

FILE: sv/lcdws_cfg_regs.sv
// Configuration register file of the LCD write sequencer.
// Depends on lcdws_pkg.
module lcdws_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    output lcdws_pkg::cfg_t      cfg
);

    lcdws_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.four_bit_mode    <= 1'b1;
            cfg_reg.function_set_cmd <= 8'h28;
            cfg_reg.display_on_cmd   <= 8'h0C;
            cfg_reg.entry_mode_cmd   <= 8'h06;
            cfg_reg.home_cmd         <= 8'h02;
            cfg_reg.clear_cmd        <= 8'h01;
        end
        else if (cfg_valid)
        begin
            case (lcdws_pkg::cfg_idx_t'(cfg_index))
                lcdws_pkg::CFG_FOUR_BIT: cfg_reg.four_bit_mode    <= cfg_data[0];
                lcdws_pkg::CFG_FUNC_SET: cfg_reg.function_set_cmd <= cfg_data;
                lcdws_pkg::CFG_DISP_ON:  cfg_reg.display_on_cmd   <= cfg_data;
                lcdws_pkg::CFG_ENTRY:    cfg_reg.entry_mode_cmd   <= cfg_data;
                lcdws_pkg::CFG_HOME:     cfg_reg.home_cmd         <= cfg_data;
                lcdws_pkg::CFG_CLEAR:    cfg_reg.clear_cmd        <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: sv/lcdws_sequencer.sv
// Microcode sequencer: dispatch on request kind, step counter, mode-dependent skips.
// Depends on lcdws_pkg (microcode table and control word type).
module lcdws_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           kind,
    input  logic [2:0]           row,
    input  logic                 four_bit_mode,
    input  logic                 out_free,
    output logic                 accept,
    output logic                 emit,
    output lcdws_pkg::uword_t    cw
);

    logic                        busy_reg, busy_next;
    logic [lcdws_pkg::PC_W-1:0]  pc_reg, pc_next;
    logic                        start_ok;
    logic [lcdws_pkg::PC_W-1:0]  start_pc;
    logic                        skip;

    always_comb
    begin
        start_ok = 1'b1;
        start_pc = lcdws_pkg::ENT_CHAR;
        case (lcdws_pkg::kind_t'(kind))
            lcdws_pkg::KIND_CHAR:   start_pc = lcdws_pkg::ENT_CHAR;
            lcdws_pkg::KIND_CMD:    start_pc = lcdws_pkg::ENT_CMD;
            lcdws_pkg::KIND_CURSOR:
            begin
                start_pc = lcdws_pkg::ENT_CMD;
                start_ok = (row >= 3'd1) && (row <= 3'd4);
            end
            lcdws_pkg::KIND_INIT:   start_pc = lcdws_pkg::ENT_INIT;
            lcdws_pkg::KIND_CLEAR:  start_pc = lcdws_pkg::ENT_CLEAR;
            default:                start_ok = 1'b0;
        endcase
    end

    assign in_ready = ~busy_reg;
    assign accept   = in_valid & in_ready;
    assign cw       = lcdws_pkg::ucode(pc_reg);
    // high nibble words and four-bit-only words fall through in 8-bit mode
    assign skip     = ~four_bit_mode & (cw.nib_hi | cw.four_only);
    assign emit     = busy_reg & out_free & ~skip;

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (accept)
        begin
            busy_next = start_ok;
            pc_next   = start_pc;
        end
        else if (busy_reg && (skip || emit))
        begin
            if (emit && cw.last)
                busy_next = 1'b0;
            else
                pc_next = pc_reg + lcdws_pkg::PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    a_start_loads_entry: assert property (@(posedge clk) disable iff (!rst_n)
        accept && start_ok |=> busy_reg && pc_reg == $past(start_pc))
        else $error("sequencer did not start at program entry");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        emit && cw.last |=> !busy_reg)
        else $error("run continued past its last segment");

    a_pc_in_rom: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg < lcdws_pkg::PC_W'(lcdws_pkg::ROM_DEPTH))
        else $error("step counter left the microcode table");

endmodule

FILE: sv/lcdws_datapath.sv
// Datapath: request byte latch, cursor address, byte and nibble select, output register.
// Depends on lcdws_pkg; driven by lcdws_sequencer control words.
module lcdws_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [2:0]           kind,
    input  logic [7:0]           byte_value,
    input  logic [2:0]           row,
    input  logic [5:0]           column,
    input  lcdws_pkg::cfg_t      cfg,
    input  logic                 emit,
    input  lcdws_pkg::uword_t    cw,
    output logic                 out_free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           data_lines,
    output logic                 reg_select,
    output logic                 enable,
    output logic [17:0]          hold_us,
    output logic                 last
);

    logic [7:0]  req_byte_reg;
    logic [7:0]  base;
    logic [7:0]  cursor_addr;
    logic [7:0]  sel_byte;
    logic [7:0]  data_next;
    logic [lcdws_pkg::HOLD_W-1:0] hold_next;
    logic        out_valid_reg;
    logic [7:0]  data_lines_reg;
    logic        reg_select_reg;
    logic        enable_reg;
    logic [17:0] hold_us_reg;
    logic        last_reg;

    always_comb
    begin
        case (row)
            3'd1:    base = lcdws_pkg::ROW1_BASE;
            3'd2:    base = lcdws_pkg::ROW2_BASE;
            3'd3:    base = lcdws_pkg::ROW3_BASE;
            3'd4:    base = lcdws_pkg::ROW4_BASE;
            default: base = 8'h00;
        endcase
    end

    assign cursor_addr = base + {2'b00, column} - 8'd1;

    always_ff @(posedge clk)
    begin
        if (accept)
            req_byte_reg <= (lcdws_pkg::kind_t'(kind) == lcdws_pkg::KIND_CURSOR)
                            ? cursor_addr : byte_value;
    end

    always_comb
    begin
        case (cw.src)
            lcdws_pkg::SRC_REQ:   sel_byte = req_byte_reg;
            lcdws_pkg::SRC_HOME:  sel_byte = cfg.home_cmd;
            lcdws_pkg::SRC_FUNC:  sel_byte = cfg.function_set_cmd;
            lcdws_pkg::SRC_DISP:  sel_byte = cfg.display_on_cmd;
            lcdws_pkg::SRC_CLEAR: sel_byte = cfg.clear_cmd;
            lcdws_pkg::SRC_ENTRY: sel_byte = cfg.entry_mode_cmd;
            default:              sel_byte = 8'h00;
        endcase

        if (cw.nib_hi)
            data_next = {4'h0, sel_byte[7:4]};
        else if (cfg.four_bit_mode)
            data_next = {4'h0, sel_byte[3:0]};
        else
            data_next = sel_byte;

        case (cw.hold)
            lcdws_pkg::HOLD_PULSE: hold_next = lcdws_pkg::HOLD_PULSE_VAL;
            lcdws_pkg::HOLD_GAP:   hold_next = lcdws_pkg::HOLD_GAP_VAL;
            lcdws_pkg::HOLD_CLEAR: hold_next = lcdws_pkg::HOLD_CLEAR_VAL;
            lcdws_pkg::HOLD_INIT:  hold_next = lcdws_pkg::HOLD_INIT_VAL;
            default:               hold_next = lcdws_pkg::HOLD_PULSE_VAL;
        endcase
    end

    assign out_free = ~out_valid_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_lines_reg <= data_next;
            reg_select_reg <= cw.rs;
            enable_reg     <= cw.en;
            hold_us_reg    <= hold_next;
            last_reg       <= cw.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_lines = data_lines_reg;
    assign reg_select = reg_select_reg;
    assign enable     = enable_reg;
    assign hold_us    = hold_us_reg;
    assign last       = last_reg;

    a_nibble_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        emit && cfg.four_bit_mode |=> data_lines_reg[7:4] == 4'h0)
        else $error("upper data lines driven in four-bit mode");

endmodule

FILE: sv/char_lcd_write_sequencer.sv
// Character LCD write sequencer, top level: config registers, microcode sequencer, datapath.
// Depends on lcdws_pkg, lcdws_cfg_regs, lcdws_sequencer, lcdws_datapath.
// Order: an accepted request loads the step counter, then each emitted segment is registered in the
// output register; for a byte in 8-bit mode the two high-nibble steps are skipped first.
// Throughput: at most one segment per cycle while the output is not stalled (8-bit mode skips
// still cost one microcode step each); a new request is accepted only after the previous run ends.
// Reset: asynchronous, active low; config returns to defaults, sequencer idles, no output valid.
module char_lcd_write_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [7:0]  byte_value,
    input  logic [2:0]  row,
    input  logic [5:0]  column,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_lines,
    output logic        reg_select,
    output logic        enable,
    output logic [17:0] hold_us,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    lcdws_pkg::cfg_t   cfg;
    lcdws_pkg::uword_t cw;
    logic              accept;
    logic              emit;
    logic              out_free;

    lcdws_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lcdws_sequencer u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .row           (row),
        .four_bit_mode (cfg.four_bit_mode),
        .out_free      (out_free),
        .accept        (accept),
        .emit          (emit),
        .cw            (cw)
    );

    lcdws_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .kind       (kind),
        .byte_value (byte_value),
        .row        (row),
        .column     (column),
        .cfg        (cfg),
        .emit       (emit),
        .cw         (cw),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_lines (data_lines),
        .reg_select (reg_select),
        .enable     (enable),
        .hold_us    (hold_us),
        .last       (last)
    );

endmodule

FILE: dv/tb.sv
// Testbench for char_lcd_write_sequencer: drives LCD requests and config writes, predicts
// each pin segment in a local model and checks every segment that comes out.
// Depends on lcdws_pkg and the char_lcd_write_sequencer RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAIL_CYCLES = 60;
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_value;
        logic [2:0] row;
        logic [5:0] column;
    } lcd_req_t;

    typedef struct packed {
        logic [7:0]  data_lines;
        logic        reg_select;
        logic        enable;
        logic [17:0] hold_us;
        logic        last;
    } pin_seg_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    lcd_req_t    drv_req = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  data_lines;
    logic        reg_select;
    logic        enable;
    logic [17:0] hold_us;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    lcd_req_t        pend_q[$];
    pin_seg_t        want_q[$];
    lcdws_pkg::cfg_t lcd_cfg;
    logic            calm = 1'b0;
    int              n_errors = 0;
    int              n_reqs = 0;
    int              n_segs = 0;
    int              n_inits = 0;
    int              quiet_cycles = 0;

    char_lcd_write_sequencer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (drv_req.kind),
        .byte_value (drv_req.byte_value),
        .row        (drv_req.row),
        .column     (drv_req.column),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_lines (data_lines),
        .reg_select (reg_select),
        .enable     (enable),
        .hold_us    (hold_us),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic void queue_seg(logic [7:0] d, logic rs, logic en, int hold);
        pin_seg_t s;
        s.data_lines = d;
        s.reg_select = rs;
        s.enable     = en;
        s.hold_us    = (hold > lcdws_pkg::HOLD_MAX) ? 18'(lcdws_pkg::HOLD_MAX) : 18'(hold);
        s.last       = 1'b0;
        want_q.push_back(s);
    endfunction

    // extra wait lands on the final enable-low segment of the byte
    function automatic void queue_byte(logic [7:0] b, logic rs, int extra);
        if (lcd_cfg.four_bit_mode)
        begin
            queue_seg({4'h0, b[7:4]}, rs, 1'b1, lcdws_pkg::PULSE_US);
            queue_seg({4'h0, b[7:4]}, rs, 1'b0, lcdws_pkg::PULSE_US);
            queue_seg({4'h0, b[3:0]}, rs, 1'b1, lcdws_pkg::PULSE_US);
            queue_seg({4'h0, b[3:0]}, rs, 1'b0, lcdws_pkg::PULSE_US + extra);
        end
        else
        begin
            queue_seg(b, rs, 1'b1, lcdws_pkg::PULSE_US);
            queue_seg(b, rs, 1'b0, lcdws_pkg::PULSE_US + extra);
        end
    endfunction

    function automatic void predict_segments(lcd_req_t req);
        int         depth0;
        logic [7:0] base;
        logic       row_ok;
        depth0 = want_q.size();
        base   = lcdws_pkg::ROW1_BASE;
        row_ok = 1'b1;
        case (req.kind)
            lcdws_pkg::KIND_CHAR:  queue_byte(req.byte_value, 1'b1, 0);
            lcdws_pkg::KIND_CMD:   queue_byte(req.byte_value, 1'b0, 0);
            lcdws_pkg::KIND_CURSOR:
            begin
                case (req.row)
                    3'd1: base = lcdws_pkg::ROW1_BASE;
                    3'd2: base = lcdws_pkg::ROW2_BASE;
                    3'd3: base = lcdws_pkg::ROW3_BASE;
                    3'd4: base = lcdws_pkg::ROW4_BASE;
                    default: row_ok = 1'b0;
                endcase
                if (row_ok)
                    queue_byte(8'(base + {2'b00, req.column} - 8'd1), 1'b0, 0);
            end
            lcdws_pkg::KIND_INIT:
            begin
                queue_seg(8'h00, 1'b0, 1'b0, lcdws_pkg::INIT_WAIT_US);
                if (lcd_cfg.four_bit_mode)
                    queue_byte(lcd_cfg.home_cmd, 1'b0, lcdws_pkg::CMD_GAP_US);
                queue_byte(lcd_cfg.function_set_cmd, 1'b0, lcdws_pkg::CMD_GAP_US);
                queue_byte(lcd_cfg.display_on_cmd, 1'b0, lcdws_pkg::CMD_GAP_US);
                queue_byte(lcd_cfg.clear_cmd, 1'b0, lcdws_pkg::CLEAR_WAIT_US);
                queue_byte(lcd_cfg.entry_mode_cmd, 1'b0, lcdws_pkg::CMD_GAP_US);
            end
            lcdws_pkg::KIND_CLEAR: queue_byte(lcd_cfg.clear_cmd, 1'b0, lcdws_pkg::CLEAR_WAIT_US);
            default: ;
        endcase
        if (want_q.size() > depth0)
            want_q[want_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void add_req(logic [2:0] k, logic [7:0] b, logic [2:0] r, logic [5:0] c);
        lcd_req_t req;
        req.kind       = k;
        req.byte_value = b;
        req.row        = r;
        req.column     = c;
        pend_q.push_back(req);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_segments(drv_req);
                n_reqs++;
                if (drv_req.kind == lcdws_pkg::KIND_INIT)
                    n_inits++;
            end
            if (!in_valid || in_ready)
            begin
                if (pend_q.size() != 0 && (calm || $urandom_range(0, 99) >= 25))
                begin
                    drv_req  <= pend_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        pin_seg_t got;
        pin_seg_t exp_seg;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{data_lines, reg_select, enable, hold_us, last};
                n_segs++;
                if (want_q.size() == 0)
                begin
                    report($sformatf("segment with none expected: %p", got));
                end
                else
                begin
                    exp_seg = want_q.pop_front();
                    if (got.data_lines !== exp_seg.data_lines)
                        report($sformatf("data_lines %h, want %h",
                                         got.data_lines, exp_seg.data_lines));
                    if (got.reg_select !== exp_seg.reg_select)
                        report($sformatf("reg_select %b, want %b",
                                         got.reg_select, exp_seg.reg_select));
                    if (got.enable !== exp_seg.enable)
                        report($sformatf("enable %b, want %b", got.enable, exp_seg.enable));
                    if (got.hold_us !== exp_seg.hold_us)
                        report($sformatf("hold_us %0d, want %0d",
                                         got.hold_us, exp_seg.hold_us));
                    if (got.last !== exp_seg.last)
                        report($sformatf("last %b, want %b", got.last, exp_seg.last));
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    // watchdog: cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("ERROR: no handshake for %0d cycles", quiet_cycles);
                $display("tb: FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic write_reg(lcdws_pkg::cfg_idx_t idx, logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            lcdws_pkg::CFG_FOUR_BIT: lcd_cfg.four_bit_mode    = val[0];
            lcdws_pkg::CFG_FUNC_SET: lcd_cfg.function_set_cmd = val;
            lcdws_pkg::CFG_DISP_ON:  lcd_cfg.display_on_cmd   = val;
            lcdws_pkg::CFG_ENTRY:    lcd_cfg.entry_mode_cmd   = val;
            lcdws_pkg::CFG_HOME:     lcd_cfg.home_cmd         = val;
            lcdws_pkg::CFG_CLEAR:    lcd_cfg.clear_cmd        = val;
            default: ;
        endcase
    endtask

    // sender holds off until every expected segment is back, then lets the block settle
    task automatic drain();
        while (pend_q.size() != 0 || in_valid || want_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic run_batch(int count);
        lcd_req_t req;
        int       pick;
        repeat (count)
        begin
            pick           = $urandom_range(0, 99);
            req.byte_value = 8'($urandom_range(0, 255));
            req.row        = 3'($urandom_range(0, 7));
            req.column     = 6'($urandom_range(0, 63));
            if (pick < 20)
                req.kind = lcdws_pkg::KIND_CHAR;
            else if (pick < 38)
                req.kind = lcdws_pkg::KIND_CMD;
            else if (pick < 65)
            begin
                req.kind = lcdws_pkg::KIND_CURSOR;
                if ($urandom_range(0, 99) < 85)
                    req.row = 3'($urandom_range(1, 4));
            end
            else if (pick < 76)
                req.kind = lcdws_pkg::KIND_INIT;
            else if (pick < 90)
                req.kind = lcdws_pkg::KIND_CLEAR;
            else
                req.kind = 3'($urandom_range(5, 7));
            pend_q.push_back(req);
        end
        drain();
    endtask

    initial
    begin
        lcd_cfg = '{four_bit_mode: 1'b1, function_set_cmd: 8'h28, display_on_cmd: 8'h0C,
                    entry_mode_cmd: 8'h06, home_cmd: 8'h02, clear_cmd: 8'h01};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset config, four-bit bus
        add_req(lcdws_pkg::KIND_CHAR, 8'h00, 3'd0, 6'd0);
        add_req(lcdws_pkg::KIND_CHAR, 8'hFF, 3'd7, 6'd63);
        add_req(lcdws_pkg::KIND_CMD, 8'hA5, 3'd0, 6'd0);
        add_req(lcdws_pkg::KIND_CMD, 8'h5A, 3'd0, 6'd0);
        add_req(lcdws_pkg::KIND_CURSOR, 8'h00, 3'd1, 6'd1);
        add_req(lcdws_pkg::KIND_CURSOR, 8'h00, 3'd2, 6'd20);
        add_req(lcdws_pkg::KIND_CURSOR, 8'h00, 3'd3, 6'd0);    // column zero lands one below base
        add_req(lcdws_pkg::KIND_CURSOR, 8'h00, 3'd4, 6'd63);
        add_req(lcdws_pkg::KIND_CURSOR, 8'h00, 3'd0, 6'd5);    // bad rows: nothing out
        add_req(lcdws_pkg::KIND_CURSOR, 8'h00, 3'd5, 6'd1);
        add_req(lcdws_pkg::KIND_CURSOR, 8'hFF, 3'd7, 6'd63);
        add_req(lcdws_pkg::KIND_INIT, 8'h00, 3'd0, 6'd0);
        add_req(lcdws_pkg::KIND_CLEAR, 8'h00, 3'd0, 6'd0);
        add_req(3'd5, 8'h11, 3'd1, 6'd1);           // unknown kinds: nothing out
        add_req(3'd6, 8'h22, 3'd2, 6'd2);
        add_req(3'd7, 8'hFF, 3'd7, 6'd63);
        drain();

        // eight-bit bus, other regs at reset
        write_reg(lcdws_pkg::CFG_FOUR_BIT, 8'h00);
        add_req(lcdws_pkg::KIND_INIT, 8'h00, 3'd0, 6'd0);
        add_req(lcdws_pkg::KIND_CLEAR, 8'h00, 3'd0, 6'd0);
        add_req(lcdws_pkg::KIND_CHAR, 8'h3C, 3'd0, 6'd0);
        add_req(lcdws_pkg::KIND_CURSOR, 8'h00, 3'd2, 6'd0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            logic [7:0] fill;
            fill = 8'($urandom_range(0, 255));
            if (ph == 0)
                fill = 8'h00;
            else if (ph == 1)
                fill = 8'hFF;
            write_reg(lcdws_pkg::CFG_FOUR_BIT, (ph % 2 == 1) ? 8'hFF : 8'h00);
            write_reg(lcdws_pkg::CFG_FUNC_SET, fill);
            write_reg(lcdws_pkg::CFG_DISP_ON, (ph < 2) ? fill : 8'($urandom_range(0, 255)));
            write_reg(lcdws_pkg::CFG_ENTRY, (ph < 2) ? fill : 8'($urandom_range(0, 255)));
            write_reg(lcdws_pkg::CFG_HOME, (ph < 2) ? fill : 8'($urandom_range(0, 255)));
            write_reg(lcdws_pkg::CFG_CLEAR, (ph < 2) ? fill : 8'($urandom_range(0, 255)));
            calm = (ph == 2);
            run_batch(25);
            calm = 1'b0;
        end

        if (want_q.size() != 0)
            report($sformatf("%0d segments never came out", want_q.size()));
        $display("tb: %0d requests (%0d init runs), %0d segments checked", n_reqs, n_inits,
                 n_segs);
        $display("tb: four- and eight-bit buses, command bytes at 0x00, 0xFF and random");
        if (n_errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: char_lcd_write_sequencer.f
sv/lcdws_pkg.sv
sv/lcdws_cfg_regs.sv
sv/lcdws_sequencer.sv
sv/lcdws_datapath.sv
sv/char_lcd_write_sequencer.sv
dv/tb.sv
